/* hdl/crp_table_seating_sampler_unit_assert.svh */
// Assertion shorthands for the table seating sampler.
// Each one samples on the rising edge of clk and is off while rst_n is low.
`ifndef CRP_TABLE_SEATING_SAMPLER_UNIT_ASSERT_SVH
`define CRP_TABLE_SEATING_SAMPLER_UNIT_ASSERT_SVH

// Check a condition at every edge.
`define CRP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle.
`define CRP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the next cycle.
`define CRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/crp_pkg.sv */
`timescale 1ns / 1ps

package crp_pkg;

    localparam int MAX_TABLES = 64;
    localparam int COUNT_BITS = 16;

    localparam int IDX_W      = $clog2(MAX_TABLES);
    localparam int OCC_W      = $clog2(MAX_TABLES + 1);
    localparam int N_W        = 16;
    localparam int ALPHA_W    = 16;
    localparam int ALPHA_FRAC = 8;
    localparam int DRAW_W     = 16;

    // n*2^8 + alpha needs one bit above n*2^8; the seat test multiplies by count_sum
    localparam int FRESH_B_W  = N_W + ALPHA_FRAC + 1;
    localparam int MUL_B_W    = (COUNT_BITS > FRESH_B_W) ? COUNT_BITS : FRESH_B_W;
    localparam int PROD_W     = DRAW_W + MUL_B_W;
    localparam int CMP_W      = PROD_W + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        ACT_ADD         = 2'd0,
        ACT_REMOVE      = 2'd1,
        ACT_REMOVE_LAST = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_STALE = 2'd3
    } status_t;

    typedef struct packed {
        logic               en;
        logic [DRAW_W-1:0]  a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

endpackage

/* hdl/crp_count_ram.sv */
`timescale 1ns / 1ps

module crp_count_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/crp_mul_unit.sv */
`timescale 1ns / 1ps

// Registered draw-by-weight multiplier, shared by the new-table and seat tests.
module crp_mul_unit (
    input  logic                      clk,
    input  crp_pkg::mul_req_t         req,
    output logic [crp_pkg::PROD_W-1:0] prod
);

    logic [crp_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= crp_pkg::PROD_W'(req.a) * crp_pkg::PROD_W'(req.b);
        end
    end

    assign prod = prod_reg;

endmodule

/* hdl/crp_table_seating_sampler_unit.sv */
`timescale 1ns / 1ps

// Chinese restaurant process seating sampler: keeps up to 64 per-table customer
// counts in a compact list and, for each input item, adds a customer (new table
// or an existing one chosen by draw_seat), removes a random customer, or undoes
// the last add, then returns exactly one result item with the touched table,
// the table count, the seated total and a status code. One item is in work at a
// time; in_stall stays high from acceptance until the result is loaded into the
// output register, which may still be waiting while the next item is accepted.
// Errors and unused actions need no count access, a new table is written from
// S_FRESH_TEST, and a seat search or removal walks the count memory one table
// per cycle through its single read port; an erase walks the later tables down
// one per cycle through the same port. The draw products come from one
// registered 16 x 25 multiplier used by both tests.
// concentration is written through cfg_write_en/cfg_write_data and must only
// change while the block is idle. No clearing pass runs after reset.
module crp_table_seating_sampler_unit (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_write_en,
    input  logic [crp_pkg::ALPHA_W-1:0]     cfg_write_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      action,
    input  logic [crp_pkg::N_W-1:0]         parent_customers,
    input  logic [crp_pkg::DRAW_W-1:0]      draw_parent,
    input  logic [crp_pkg::DRAW_W-1:0]      draw_seat,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            table_created,
    output logic                            table_deleted,
    output logic [crp_pkg::IDX_W-1:0]       seat_index,
    output logic [crp_pkg::OCC_W-1:0]       tables_in_use,
    output logic [crp_pkg::COUNT_BITS-1:0]  seated_total,
    output logic [1:0]                      status
);

    `include "crp_table_seating_sampler_unit_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_FRESH_TEST,
        S_SEAT_MUL,
        S_SCAN,
        S_LOAD,
        S_MODIFY,
        S_SHIFT,
        S_FINISH
    } state_t;

    state_t                          state_reg, state_next;

    // item fields held for the whole item
    logic [1:0]                      action_reg, action_next;
    logic [crp_pkg::N_W-1:0]         n_reg, n_next;
    logic [crp_pkg::DRAW_W-1:0]      dp_reg, dp_next;
    logic [crp_pkg::DRAW_W-1:0]      ds_reg, ds_next;
    logic [crp_pkg::ALPHA_W-1:0]     alpha_reg, alpha_next;

    // seating state
    logic [crp_pkg::OCC_W-1:0]       occ_reg, occ_next;
    logic [crp_pkg::COUNT_BITS-1:0]  sum_reg, sum_next;
    logic [crp_pkg::IDX_W-1:0]       last_reg, last_next;

    // work registers
    logic [crp_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic [crp_pkg::IDX_W-1:0]       walk_reg, walk_next;
    logic [crp_pkg::COUNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [crp_pkg::COUNT_BITS-1:0]  prefix_reg, prefix_next;
    logic                            res_created_reg, res_created_next;
    logic                            res_deleted_reg, res_deleted_next;
    crp_pkg::status_t                res_status_reg, res_status_next;

    // output register
    logic                            out_valid_reg, out_valid_next;
    logic                            table_created_reg, table_created_next;
    logic                            table_deleted_reg, table_deleted_next;
    logic [crp_pkg::IDX_W-1:0]       seat_index_reg, seat_index_next;
    logic [crp_pkg::OCC_W-1:0]       tables_in_use_reg, tables_in_use_next;
    logic [crp_pkg::COUNT_BITS-1:0]  seated_total_reg, seated_total_next;
    crp_pkg::status_t                status_reg, status_next;

    // shared units
    crp_pkg::mul_req_t               mul_req;
    logic [crp_pkg::PROD_W-1:0]      prod;
    logic                            ram_we;
    logic [crp_pkg::IDX_W-1:0]       ram_waddr;
    logic [crp_pkg::COUNT_BITS-1:0]  ram_wdata;
    logic [crp_pkg::IDX_W-1:0]       ram_raddr;
    logic [crp_pkg::COUNT_BITS-1:0]  ram_rdata;

    // datapath terms
    logic                            fresh;
    logic [crp_pkg::COUNT_BITS:0]    prefix_sum;
    logic                            seat_hit;
    logic [crp_pkg::COUNT_BITS-1:0]  cnt_dec;

    // checking terms
    logic                            sum_update;
    logic                            walk_in_use;
    logic                            created_tail;

    crp_mul_unit u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    crp_count_ram #(
        .DEPTH (crp_pkg::MAX_TABLES),
        .WIDTH (crp_pkg::COUNT_BITS)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // New table when the list is empty or dp * (n*2^8 + alpha) >= n * 2^24.
    assign fresh = (occ_reg == '0) ||
        (prod >= crp_pkg::PROD_W'({n_reg, {(crp_pkg::DRAW_W + crp_pkg::ALPHA_FRAC){1'b0}}}));

    // Seat test: prefix * 2^16 >= ds * total; the last in-use table always hits.
    assign prefix_sum = {1'b0, prefix_reg} + {1'b0, ram_rdata};
    assign seat_hit   =
        (crp_pkg::CMP_W'({prefix_sum, {crp_pkg::DRAW_W{1'b0}}}) >= crp_pkg::CMP_W'(prod)) ||
        (crp_pkg::OCC_W'(walk_reg) == occ_reg - crp_pkg::OCC_W'(1));

    assign cnt_dec = cnt_reg - crp_pkg::COUNT_BITS'(1);

    always_comb
    begin
        state_next         = state_reg;
        action_next        = action_reg;
        n_next             = n_reg;
        dp_next            = dp_reg;
        ds_next            = ds_reg;
        alpha_next         = alpha_reg;
        occ_next           = occ_reg;
        sum_next           = sum_reg;
        last_next          = last_reg;
        idx_next           = idx_reg;
        walk_next          = walk_reg;
        cnt_next           = cnt_reg;
        prefix_next        = prefix_reg;
        res_created_next   = res_created_reg;
        res_deleted_next   = res_deleted_reg;
        res_status_next    = res_status_reg;
        table_created_next = table_created_reg;
        table_deleted_next = table_deleted_reg;
        seat_index_next    = seat_index_reg;
        tables_in_use_next = tables_in_use_reg;
        seated_total_next  = seated_total_reg;
        status_next        = status_reg;

        // drop the result once the consumer takes it
        out_valid_next     = out_valid_reg && out_stall;

        mul_req.en = 1'b0;
        mul_req.a  = dp_reg;
        mul_req.b  = crp_pkg::MUL_B_W'({n_reg, {crp_pkg::ALPHA_FRAC{1'b0}}}) +
                     crp_pkg::MUL_B_W'(alpha_reg);

        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = cnt_reg;
        ram_raddr = walk_reg;

        if (cfg_write_en)
        begin
            alpha_next = cfg_write_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    action_next = action;
                    n_next      = parent_customers;
                    dp_next     = draw_parent;
                    ds_next     = draw_seat;
                    state_next  = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                res_created_next = 1'b0;
                res_deleted_next = 1'b0;
                res_status_next  = crp_pkg::ST_OK;
                idx_next         = '0;
                unique case (action_reg)
                    crp_pkg::ACT_ADD:
                    begin
                        if (sum_reg == crp_pkg::COUNT_MAX)
                        begin
                            res_status_next = crp_pkg::ST_FULL;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            mul_req.en = 1'b1;
                            state_next = S_FRESH_TEST;
                        end
                    end
                    crp_pkg::ACT_REMOVE:
                    begin
                        if (occ_reg == '0)
                        begin
                            res_status_next = crp_pkg::ST_EMPTY;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SEAT_MUL;
                        end
                    end
                    crp_pkg::ACT_REMOVE_LAST:
                    begin
                        if (occ_reg == '0)
                        begin
                            res_status_next = crp_pkg::ST_EMPTY;
                            state_next      = S_FINISH;
                        end
                        else if (crp_pkg::OCC_W'(last_reg) >= occ_reg)
                        begin
                            res_status_next = crp_pkg::ST_STALE;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            idx_next   = last_reg;
                            ram_raddr  = last_reg;
                            state_next = S_LOAD;
                        end
                    end
                    default:
                    begin
                        // unused action: report the state untouched
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_FRESH_TEST:
            begin
                if (fresh)
                begin
                    if (occ_reg >= crp_pkg::OCC_W'(crp_pkg::MAX_TABLES))
                    begin
                        res_status_next = crp_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_we           = 1'b1;
                        ram_waddr        = crp_pkg::IDX_W'(occ_reg);
                        ram_wdata        = crp_pkg::COUNT_BITS'(1);
                        idx_next         = crp_pkg::IDX_W'(occ_reg);
                        last_next        = crp_pkg::IDX_W'(occ_reg);
                        occ_next         = occ_reg + crp_pkg::OCC_W'(1);
                        sum_next         = sum_reg + crp_pkg::COUNT_BITS'(1);
                        res_created_next = 1'b1;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SEAT_MUL;
                end
            end

            S_SEAT_MUL:
            begin
                // target product and the first count land together
                mul_req.en  = 1'b1;
                mul_req.a   = ds_reg;
                mul_req.b   = crp_pkg::MUL_B_W'(sum_reg);
                ram_raddr   = '0;
                walk_next   = '0;
                prefix_next = '0;
                state_next  = S_SCAN;
            end

            S_SCAN:
            begin
                ram_raddr = walk_reg + crp_pkg::IDX_W'(1);
                if (seat_hit)
                begin
                    idx_next   = walk_reg;
                    cnt_next   = ram_rdata;
                    state_next = S_MODIFY;
                end
                else
                begin
                    walk_next   = walk_reg + crp_pkg::IDX_W'(1);
                    prefix_next = prefix_sum[crp_pkg::COUNT_BITS-1:0];
                end
            end

            S_LOAD:
            begin
                cnt_next   = ram_rdata;
                state_next = S_MODIFY;
            end

            S_MODIFY:
            begin
                if (action_reg == crp_pkg::ACT_ADD)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = cnt_reg + crp_pkg::COUNT_BITS'(1);
                    sum_next   = sum_reg + crp_pkg::COUNT_BITS'(1);
                    last_next  = idx_reg;
                    state_next = S_FINISH;
                end
                else
                begin
                    sum_next = sum_reg - crp_pkg::COUNT_BITS'(1);
                    if (cnt_dec != '0)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = cnt_dec;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        res_deleted_next = 1'b1;
                        if (crp_pkg::OCC_W'(idx_reg) + crp_pkg::OCC_W'(1) < occ_reg)
                        begin
                            // erase: start moving later tables down
                            ram_raddr  = idx_reg + crp_pkg::IDX_W'(1);
                            walk_next  = idx_reg;
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            occ_next   = occ_reg - crp_pkg::OCC_W'(1);
                            state_next = S_FINISH;
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = walk_reg;
                ram_wdata = ram_rdata;
                ram_raddr = walk_reg + crp_pkg::IDX_W'(2);
                if (crp_pkg::OCC_W'(walk_reg) + crp_pkg::OCC_W'(2) == occ_reg)
                begin
                    occ_next   = occ_reg - crp_pkg::OCC_W'(1);
                    state_next = S_FINISH;
                end
                else
                begin
                    walk_next = walk_reg + crp_pkg::IDX_W'(1);
                end
            end

            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next     = 1'b1;
                    table_created_next = res_created_reg;
                    table_deleted_next = res_deleted_reg;
                    seat_index_next    = idx_reg;
                    tables_in_use_next = occ_reg;
                    seated_total_next  = sum_reg;
                    status_next        = res_status_reg;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            action_reg        <= '0;
            n_reg             <= '0;
            dp_reg            <= '0;
            ds_reg            <= '0;
            alpha_reg         <= crp_pkg::ALPHA_W'(256);
            occ_reg           <= '0;
            sum_reg           <= '0;
            last_reg          <= '0;
            idx_reg           <= '0;
            walk_reg          <= '0;
            cnt_reg           <= '0;
            prefix_reg        <= '0;
            res_created_reg   <= 1'b0;
            res_deleted_reg   <= 1'b0;
            res_status_reg    <= crp_pkg::ST_OK;
            out_valid_reg     <= 1'b0;
            table_created_reg <= 1'b0;
            table_deleted_reg <= 1'b0;
            seat_index_reg    <= '0;
            tables_in_use_reg <= '0;
            seated_total_reg  <= '0;
            status_reg        <= crp_pkg::ST_OK;
        end
        else
        begin
            state_reg         <= state_next;
            action_reg        <= action_next;
            n_reg             <= n_next;
            dp_reg            <= dp_next;
            ds_reg            <= ds_next;
            alpha_reg         <= alpha_next;
            occ_reg           <= occ_next;
            sum_reg           <= sum_next;
            last_reg          <= last_next;
            idx_reg           <= idx_next;
            walk_reg          <= walk_next;
            cnt_reg           <= cnt_next;
            prefix_reg        <= prefix_next;
            res_created_reg   <= res_created_next;
            res_deleted_reg   <= res_deleted_next;
            res_status_reg    <= res_status_next;
            out_valid_reg     <= out_valid_next;
            table_created_reg <= table_created_next;
            table_deleted_reg <= table_deleted_next;
            seat_index_reg    <= seat_index_next;
            tables_in_use_reg <= tables_in_use_next;
            seated_total_reg  <= seated_total_next;
            status_reg        <= status_next;
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign table_created = table_created_reg;
    assign table_deleted = table_deleted_reg;
    assign seat_index    = seat_index_reg;
    assign tables_in_use = tables_in_use_reg;
    assign seated_total  = seated_total_reg;
    assign status        = status_reg;

    assign sum_update   = (state_reg == S_FRESH_TEST) || (state_reg == S_MODIFY);
    assign walk_in_use  = crp_pkg::OCC_W'(walk_reg) < occ_reg;
    assign created_tail = (status_reg == crp_pkg::ST_OK) &&
        (crp_pkg::OCC_W'(seat_index_reg) + crp_pkg::OCC_W'(1) == tables_in_use_reg);

    `CRP_ASSERT_ALWAYS(a_occ_bound, occ_reg <= crp_pkg::OCC_W'(crp_pkg::MAX_TABLES), "too many tables")

    `CRP_ASSERT_IMPLY(a_scan_in_use, state_reg == S_SCAN, walk_in_use, "search left the used tables")

    `CRP_ASSERT_IMPLY(a_created_is_last, out_valid_reg && table_created_reg, created_tail, "new table not last")

    `CRP_ASSERT_NEXT(a_sum_hold, !sum_update, sum_reg == $past(sum_reg), "total moved outside an update")

endmodule
